>>> rtl/sntp_chk_pkg.sv
`timescale 1ns / 1ps
// shared constants, status codes and stream widths for the sntp response checker
// no dependencies
package sntp_chk_pkg;

  // minimum length of an sntp header in bytes
  localparam logic [10:0] MIN_PACKET_BYTES = 11'd48;

  localparam logic [2:0]  MODE_SERVER = 3'd4;
  localparam logic [7:0]  KOD_STRATUM = 8'd0;
  localparam logic [31:0] KISS_DENY   = 32'h4445_4e59;
  localparam logic [31:0] KISS_RSTR   = 32'h5253_5452;
  localparam logic [31:0] KISS_RATE   = 32'h5241_5445;

  localparam int IN_TDATA_W  = 320;
  localparam int OUT_TDATA_W = 136;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_INVALID = 3'd2,
    ST_CHANGE  = 3'd3,
    ST_BACKOFF = 3'd4,
    ST_OTHER   = 3'd5
  } status_t;

endpackage

>>> rtl/sntp_response_check_offset.sv
`timescale 1ns / 1ps
// sntp v4 response checker and clock offset computation, three register stages
// depends on sntp_chk_pkg
//
// usage:
//   one request on the slave stream carries a whole unpacked sntp response header
//   plus the received length, the client's request timestamp and the client's
//   receive seconds. each request gives exactly one result on the master stream:
//   a status, the kiss code, the server time, the leap bits and the clock offset.
//   checks run in order: length, mode, origin timestamp, stratum (kiss-of-death).
// stages: three register stages in order, the first one loading at the accepting edge
//   (stage 1 checks and raw second differences, stage 2 era fix and sum,
//   stage 3 halving, saturation and the output register)
// throughput: one request per cycle while the output is not stalled; all three stages advance together
// reset: rst clears the valid bits of all stages; nothing is in flight afterwards
// stall: when the result is held by m_axis_tready low, the whole pipeline freezes
//   and s_axis_tready drops; bubbles inside the pipeline are not squeezed out,
//   a pipeline step only happens when the output register is empty or being taken
module sntp_response_check_offset (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // packet_length[10:0], first_byte[18:11], stratum[26:19], reference_id[58:27],
  // origin_time[122:59], server_receive_seconds[154:123],
  // server_transmit_time[218:155], request_time[282:219],
  // client_receive_seconds[314:283], zero fill [319:315]
  input  logic [sntp_chk_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // status[2:0], kiss_code[34:3], server_time[98:35], leap_info[100:99],
  // clock_offset[132:101], zero fill [135:133]
  output logic [sntp_chk_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // input field unpacking
  logic [10:0] packet_length;
  logic [7:0]  first_byte;
  logic [7:0]  stratum;
  logic [31:0] reference_id;
  logic [63:0] origin_time;
  logic [31:0] server_receive_seconds;
  logic [63:0] server_transmit_time;
  logic [63:0] request_time;
  logic [31:0] client_receive_seconds;

  assign packet_length          = s_axis_tdata[10:0];
  assign first_byte             = s_axis_tdata[18:11];
  assign stratum                = s_axis_tdata[26:19];
  assign reference_id           = s_axis_tdata[58:27];
  assign origin_time            = s_axis_tdata[122:59];
  assign server_receive_seconds = s_axis_tdata[154:123];
  assign server_transmit_time   = s_axis_tdata[218:155];
  assign request_time           = s_axis_tdata[282:219];
  assign client_receive_seconds = s_axis_tdata[314:283];

  // pipeline advance: output empty or being taken
  logic advance;
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  // stage 1: checks, status and raw 33-bit second differences
  sntp_chk_pkg::status_t st1_status;
  logic [31:0]           st1_kiss;
  logic signed [32:0]    st1_d_rx;
  logic signed [32:0]    st1_d_tx;

  always_comb begin
    st1_kiss = 32'd0;
    if (packet_length < sntp_chk_pkg::MIN_PACKET_BYTES) begin
      st1_status = sntp_chk_pkg::ST_SHORT;
    end else if (first_byte[2:0] != sntp_chk_pkg::MODE_SERVER) begin
      st1_status = sntp_chk_pkg::ST_INVALID;
    end else if (origin_time != request_time) begin
      st1_status = sntp_chk_pkg::ST_INVALID;
    end else if (stratum == sntp_chk_pkg::KOD_STRATUM) begin
      st1_kiss = reference_id;
      if (reference_id == sntp_chk_pkg::KISS_DENY ||
          reference_id == sntp_chk_pkg::KISS_RSTR) begin
        st1_status = sntp_chk_pkg::ST_CHANGE;
      end else if (reference_id == sntp_chk_pkg::KISS_RATE) begin
        st1_status = sntp_chk_pkg::ST_BACKOFF;
      end else begin
        st1_status = sntp_chk_pkg::ST_OTHER;
      end
    end else begin
      st1_status = sntp_chk_pkg::ST_OK;
    end
  end

  // t2 - t1 and t3 - t4, seconds only
  assign st1_d_rx = $signed({1'b0, server_receive_seconds}) -
                    $signed({1'b0, request_time[63:32]});
  assign st1_d_tx = $signed({1'b0, server_transmit_time[63:32]}) -
                    $signed({1'b0, client_receive_seconds});

  logic                  v1;
  sntp_chk_pkg::status_t s1_status;
  logic [31:0]           s1_kiss;
  logic [63:0]           s1_stime;
  logic [1:0]            s1_leap;
  logic signed [32:0]    s1_d_rx;
  logic signed [32:0]    s1_d_tx;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_status <= st1_status;
      s1_kiss   <= st1_kiss;
      s1_stime  <= (st1_status == sntp_chk_pkg::ST_OK) ? server_transmit_time : 64'd0;
      s1_leap   <= (st1_status == sntp_chk_pkg::ST_OK) ? first_byte[7:6] : 2'd0;
      s1_d_rx   <= st1_d_rx;
      s1_d_tx   <= st1_d_tx;
    end
  end

  // stage 2: era resolution of each difference, then the sum
  // the wrapped 32-bit value is the nearest era; only the half-era tie needs care:
  // a plain +2^31 stays, a plain -2^31 becomes 2^31 - 1
  function automatic logic signed [32:0] era_fix(input logic signed [32:0] d);
    logic signed [32:0] r;
    if (d[31:0] == 32'h8000_0000) begin
      r = d[32] ? 33'sh0_7FFF_FFFF : 33'sh0_8000_0000;
    end else begin
      r = {d[31], d[31:0]};
    end
    return r;
  endfunction

  logic signed [32:0] st2_e_rx;
  logic signed [32:0] st2_e_tx;
  logic signed [33:0] st2_sum;

  assign st2_e_rx = era_fix(s1_d_rx);
  assign st2_e_tx = era_fix(s1_d_tx);
  assign st2_sum  = {st2_e_rx[32], st2_e_rx} + {st2_e_tx[32], st2_e_tx};

  logic                  v2;
  sntp_chk_pkg::status_t s2_status;
  logic [31:0]           s2_kiss;
  logic [63:0]           s2_stime;
  logic [1:0]            s2_leap;
  logic signed [33:0]    s2_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_status <= s1_status;
      s2_kiss   <= s1_kiss;
      s2_stime  <= s1_stime;
      s2_leap   <= s1_leap;
      s2_sum    <= st2_sum;
    end
  end

  // stage 3: halve toward zero, saturate the one overflow case (both +2^31)
  logic signed [33:0] st3_rounded;
  logic signed [33:0] st3_half;
  logic [31:0]        st3_offs;

  assign st3_rounded = s2_sum + {33'd0, s2_sum[33]};
  assign st3_half    = st3_rounded >>> 1;

  always_comb begin
    if (s2_status != sntp_chk_pkg::ST_OK) begin
      st3_offs = 32'd0;
    end else if (s2_sum == 34'sh1_0000_0000) begin
      st3_offs = 32'h7FFF_FFFF;
    end else begin
      st3_offs = st3_half[31:0];
    end
  end

  sntp_chk_pkg::status_t out_status;
  logic [31:0]           out_kiss;
  logic [63:0]           out_stime;
  logic [1:0]            out_leap;
  logic [31:0]           out_offs;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= s2_status;
      out_kiss   <= s2_kiss;
      out_stime  <= s2_stime;
      out_leap   <= s2_leap;
      out_offs   <= st3_offs;
    end
  end

  assign m_axis_tdata = {3'd0, out_offs, out_leap, out_stime, out_kiss, out_status};

  // while stalled, the inner stages hold their valid bits
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(v1) && $stable(v2))
    else $error("pipeline moved while stalled");

  // success fields are zero on every failing status
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_status != sntp_chk_pkg::ST_OK) |->
      (out_offs == 32'd0 && out_stime == 64'd0 && out_leap == 2'd0))
    else $error("success fields set on a failed response");

  // kiss code is only carried on kiss-of-death statuses
  a_kiss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_status == sntp_chk_pkg::ST_OK ||
                       out_status == sntp_chk_pkg::ST_SHORT ||
                       out_status == sntp_chk_pkg::ST_INVALID)) |->
      out_kiss == 32'd0)
    else $error("kiss code set without kiss-of-death");

  // offset never reaches the most negative value
  a_offs_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_offs != 32'h8000_0000)
    else $error("clock offset out of range");

endmodule
